>>> src/packet_framer_fletcher8_assert.svh
// Assertion macros for the packet framer.
// Used by files that check internal behavior; expects clk and arst_n in scope.
`ifndef PACKET_FRAMER_FLETCHER8_ASSERT_SVH
`define PACKET_FRAMER_FLETCHER8_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define PKF_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define PKF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/pkf_pkg.sv
// Shared types and constants for the packet framer.
// Used by the front end, the command queue, the back end and the top level.
`default_nettype none

package pkf_pkg;

	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned LEN_W       = 16;
	localparam int unsigned MAX_PAYLOAD = 128;
	localparam int unsigned CFG_IDX_W   = 1;
	localparam int unsigned CMDQ_DEPTH  = 4;
	localparam int unsigned CMDQ_AW     = 2;

	localparam logic KIND_HDR  = 1'b0;
	localparam logic KIND_DATA = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 1'd1;

	typedef struct packed {
		logic              is_hdr;
		logic [BYTE_W-1:0] class_byte;
		logic [BYTE_W-1:0] msg_id;
		logic [BYTE_W-1:0] len_lo;
		logic [BYTE_W-1:0] len_hi;
		logic [BYTE_W-1:0] data;
		logic              close;
		logic [BYTE_W-1:0] ck_a;
		logic [BYTE_W-1:0] ck_b;
	} cmd_t;

endpackage

`default_nettype wire

>>> src/pkf_front.sv
// Front end of the packet framer: accepts input items, tracks the open packet
// and the running Fletcher sums, and issues one command per frame-producing item.
// Depends on pkf_pkg.
`default_nettype none

module pkf_front (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         push,
	input  wire                         kind,
	input  wire [pkf_pkg::BYTE_W-1:0]   class_byte,
	input  wire [pkf_pkg::BYTE_W-1:0]   msg_id,
	input  wire [pkf_pkg::LEN_W-1:0]    payload_length,
	input  wire [pkf_pkg::BYTE_W-1:0]   data_byte,
	input  wire                         cmd_full,
	output logic                        cmd_push,
	output pkf_pkg::cmd_t               cmd
);
	import pkf_pkg::*;

	logic [BYTE_W-1:0] bytes_left_q;
	logic [BYTE_W-1:0] sum_a_q;
	logic [BYTE_W-1:0] sum_b_q;

	logic              accept;
	logic [LEN_W-1:0]  len_sat;
	logic [BYTE_W-1:0] len_lo;
	logic [BYTE_W-1:0] len_hi;
	logic [BYTE_W-1:0] ha1, ha2, ha3, ha4;
	logic [BYTE_W-1:0] hb2, hb3, hb4;
	logic [BYTE_W-1:0] pa, pb;

	assign accept = push && !cmd_full;

	assign len_sat = (payload_length > LEN_W'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD) : payload_length;
	assign len_lo  = len_sat[BYTE_W-1:0];
	assign len_hi  = len_sat[LEN_W-1:BYTE_W];

	assign ha1 = class_byte;
	assign ha2 = ha1 + msg_id;
	assign hb2 = ha1 + ha2;
	assign ha3 = ha2 + len_lo;
	assign hb3 = hb2 + ha3;
	assign ha4 = ha3 + len_hi;
	assign hb4 = hb3 + ha4;

	assign pa = sum_a_q + data_byte;
	assign pb = sum_b_q + pa;

	always_comb begin
		cmd.is_hdr     = (kind == KIND_HDR);
		cmd.class_byte = class_byte;
		cmd.msg_id     = msg_id;
		cmd.len_lo     = len_lo;
		cmd.len_hi     = len_hi;
		cmd.data       = data_byte;
		if (kind == KIND_HDR) begin
			cmd.close = (len_lo == '0);
			cmd.ck_a  = ha4;
			cmd.ck_b  = hb4;
		end else begin
			cmd.close = (bytes_left_q == BYTE_W'(1));
			cmd.ck_a  = pa;
			cmd.ck_b  = pb;
		end
	end

	assign cmd_push = accept && ((kind == KIND_HDR) || (bytes_left_q != '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q <= '0;
			sum_a_q      <= '0;
			sum_b_q      <= '0;
		end else if (cmd_push) begin
			sum_a_q <= cmd.ck_a;
			sum_b_q <= cmd.ck_b;
			if (kind == KIND_HDR) begin
				bytes_left_q <= len_lo;
			end else begin
				bytes_left_q <= bytes_left_q - BYTE_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

>>> src/pkf_cmd_fifo.sv
// Short command queue between the front end and the back end of the framer.
// Depends on pkf_pkg for the command type and queue depth.
`default_nettype none

module pkf_cmd_fifo (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 wr_en,
	input  wire pkf_pkg::cmd_t  wr_cmd,
	output logic                full,
	input  wire                 rd_en,
	output pkf_pkg::cmd_t       rd_cmd,
	output logic                empty
);
	import pkf_pkg::*;

	cmd_t               entry_q [CMDQ_DEPTH];
	logic [CMDQ_AW-1:0] wr_ptr_q;
	logic [CMDQ_AW-1:0] rd_ptr_q;
	logic [CMDQ_AW:0]   count_q;

	assign full   = (count_q == (CMDQ_AW+1)'(CMDQ_DEPTH));
	assign empty  = (count_q == '0);
	assign rd_cmd = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + CMDQ_AW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + CMDQ_AW'(1);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + (CMDQ_AW+1)'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - (CMDQ_AW+1)'(1);
			end
		end
	end

endmodule

`default_nettype wire

>>> src/pkf_back.sv
// Back end of the framer: expands each queued command into output bytes, one per
// cycle while pop keeps up, into a registered output stage. Depends on pkf_pkg.
`default_nettype none

module pkf_back (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire [pkf_pkg::BYTE_W-1:0]  sync_first,
	input  wire [pkf_pkg::BYTE_W-1:0]  sync_second,
	input  wire pkf_pkg::cmd_t         cmd,
	input  wire                        cmd_empty,
	output logic                       cmd_pop,
	output logic                       empty,
	input  wire                        pop,
	output logic [pkf_pkg::BYTE_W-1:0] out_byte,
	output logic                       frame_end
);
	import pkf_pkg::*;

	localparam logic [3:0] SEL_SYNC1  = 4'd0;
	localparam logic [3:0] SEL_SYNC2  = 4'd1;
	localparam logic [3:0] SEL_CLASS  = 4'd2;
	localparam logic [3:0] SEL_ID     = 4'd3;
	localparam logic [3:0] SEL_LEN_LO = 4'd4;
	localparam logic [3:0] SEL_LEN_HI = 4'd5;
	localparam logic [3:0] SEL_CK_A   = 4'd6;
	localparam logic [3:0] SEL_CK_B   = 4'd7;
	localparam logic [3:0] SEL_DATA   = 4'd8;

	localparam logic [2:0] HDR_LAST_OPEN   = 3'd5;
	localparam logic [2:0] HDR_LAST_CLOSE  = 3'd7;
	localparam logic [2:0] DATA_LAST_OPEN  = 3'd0;
	localparam logic [2:0] DATA_LAST_CLOSE = 3'd2;

	logic [2:0]        step_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_end_q;

	logic              advance;
	logic [2:0]        last_step;
	logic              at_last;
	logic [3:0]        sel;
	logic [BYTE_W-1:0] byte_next;

	assign advance = !cmd_empty && (!out_valid_q || pop);

	always_comb begin
		if (cmd.is_hdr) begin
			last_step = cmd.close ? HDR_LAST_CLOSE : HDR_LAST_OPEN;
			sel       = {1'b0, step_q};
		end else begin
			last_step = cmd.close ? DATA_LAST_CLOSE : DATA_LAST_OPEN;
			sel       = (step_q == '0) ? SEL_DATA : ({1'b0, step_q} + 4'd5);
		end
	end

	assign at_last = (step_q == last_step);
	assign cmd_pop = advance && at_last;

	always_comb begin
		unique case (sel)
			SEL_SYNC1:  byte_next = sync_first;
			SEL_SYNC2:  byte_next = sync_second;
			SEL_CLASS:  byte_next = cmd.class_byte;
			SEL_ID:     byte_next = cmd.msg_id;
			SEL_LEN_LO: byte_next = cmd.len_lo;
			SEL_LEN_HI: byte_next = cmd.len_hi;
			SEL_CK_A:   byte_next = cmd.ck_a;
			SEL_CK_B:   byte_next = cmd.ck_b;
			SEL_DATA:   byte_next = cmd.data;
			default:    byte_next = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
			step_q      <= at_last ? 3'd0 : step_q + 3'd1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_byte_q <= byte_next;
			out_end_q  <= (sel == SEL_CK_B);
		end
	end

	assign empty     = !out_valid_q;
	assign out_byte  = out_byte_q;
	assign frame_end = out_end_q;

endmodule

`default_nettype wire

>>> src/packet_framer_fletcher8.sv
// Top level of the packet framer with an 8-bit Fletcher checksum.
// Holds the sync byte registers and connects pkf_front, pkf_cmd_fifo and pkf_back.
// Depends on pkf_pkg and packet_framer_fletcher8_assert.svh.
//
// A header item produces sync, sync, class, id, length low and length high, then
// CK_A and CK_B when the length is zero; a payload byte produces the byte, then
// CK_A and CK_B on the last byte of the packet. Lengths above 128 are cut to 128,
// and payload bytes with no open packet are dropped. The output sequencer sends
// one byte per cycle while pop keeps up: a payload byte gives one byte, a header
// six (eight when empty), and a frame ending adds two. The first byte of an item
// passes through the command queue and then the output register. A four-entry
// command queue takes up to three more items while a header is being sent out;
// after that full holds the input until the header has been sent.
`default_nettype none

module packet_framer_fletcher8 (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           push,
	output logic                          full,
	input  wire                           kind,
	input  wire [pkf_pkg::BYTE_W-1:0]     class_byte,
	input  wire [pkf_pkg::BYTE_W-1:0]     msg_id,
	input  wire [pkf_pkg::LEN_W-1:0]      payload_length,
	input  wire [pkf_pkg::BYTE_W-1:0]     data_byte,
	output logic                          empty,
	input  wire                           pop,
	output logic [pkf_pkg::BYTE_W-1:0]    out_byte,
	output logic                          frame_end,
	input  wire                           cfg_valid,
	output logic                          cfg_ready,
	input  wire [pkf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire [pkf_pkg::BYTE_W-1:0]     cfg_data
);
	import pkf_pkg::*;

	`include "packet_framer_fletcher8_assert.svh"

	logic [BYTE_W-1:0] sync_first_q;
	logic [BYTE_W-1:0] sync_second_q;

	cmd_t cmd_in;
	cmd_t cmd_out;
	logic cmd_push;
	logic cmd_pop;
	logic cmd_full;
	logic cmd_empty;

	assign cfg_ready = 1'b1;
	assign full      = cmd_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= BYTE_W'(181);
			sync_second_q <= BYTE_W'(98);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SYNC_FIRST:  sync_first_q  <= cfg_data;
				REG_SYNC_SECOND: sync_second_q <= cfg_data;
				default: ;
			endcase
		end
	end

	pkf_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.kind           (kind),
		.class_byte     (class_byte),
		.msg_id         (msg_id),
		.payload_length (payload_length),
		.data_byte      (data_byte),
		.cmd_full       (cmd_full),
		.cmd_push       (cmd_push),
		.cmd            (cmd_in)
	);

	pkf_cmd_fifo u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cmd_push),
		.wr_cmd (cmd_in),
		.full   (cmd_full),
		.rd_en  (cmd_pop),
		.rd_cmd (cmd_out),
		.empty  (cmd_empty)
	);

	pkf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.sync_first  (sync_first_q),
		.sync_second (sync_second_q),
		.cmd         (cmd_out),
		.cmd_empty   (cmd_empty),
		.cmd_pop     (cmd_pop),
		.empty       (empty),
		.pop         (pop),
		.out_byte    (out_byte),
		.frame_end   (frame_end)
	);

	`PKF_ASSERT_SAME(a_cmd_no_overflow, cmd_push, !cmd_full, "Command written into a full queue.")
	`PKF_ASSERT_SAME(a_cmd_no_underflow, cmd_pop, !cmd_empty, "Command read from an empty queue.")
	`PKF_ASSERT_NEXT(a_pop_fills_output, cmd_pop, !empty, "Command finished without an output transfer.")

endmodule

`default_nettype wire
